/* sv/btm_pkg.sv */
// ----------------------------------------------------------------------------
// btm_pkg
// Shared widths, register indexes, reset values and controller states of the
// binned throughput meter.
// ----------------------------------------------------------------------------
package btm_pkg;

	localparam int MAX_RESULTS = 64;
	localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

	localparam int TS_W      = 32;
	localparam int WIDTH_W   = 24;
	localparam int WEIGHT_W  = 16;
	localparam int BYTES_W   = 16;
	localparam int BITS_W    = 32;
	localparam int RATE_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int DVD_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	localparam int DIV_STEPS = DVD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int MUL_STEPS = WEIGHT_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 24'd100000;
	localparam logic [TS_W-1:0]     CUTOFF_RESET = 32'd0;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd13107;
	localparam logic [FRAC_W-1:0]   ROUND_HALF   = 16'h8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BIN_WIDTH    = 2'd0,
		REG_OUTPUT_AFTER = 2'd1,
		REG_SMOOTHING    = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MDIV,
		ST_SAMPLE,
		ST_RDIV,
		ST_BLEND,
		ST_BWAIT,
		ST_EMIT,
		ST_FINISH
	} state_t;

endpackage

/* sv/btm_div.sv */
// ----------------------------------------------------------------------------
// btm_div
// Restoring divider, one quotient bit per cycle. The remainder starts at
// rem_init, which must lie below the divisor.
// ----------------------------------------------------------------------------
module btm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [btm_pkg::WIDTH_W-1:0]   divisor,
	input  logic [btm_pkg::WIDTH_W-1:0]   rem_init,
	input  logic [btm_pkg::DVD_W-1:0]     dividend,
	output logic                          done,
	output logic [btm_pkg::DVD_W-1:0]     quotient,
	output logic [btm_pkg::WIDTH_W-1:0]   remainder
);

	logic                            busy_q;
	logic                            done_q;
	logic [btm_pkg::DIV_CNT_W-1:0]   step_q;
	logic [btm_pkg::WIDTH_W-1:0]     rem_q;
	logic [btm_pkg::WIDTH_W-1:0]     dvs_q;
	logic [btm_pkg::DVD_W-1:0]       dvd_q;
	logic [btm_pkg::DVD_W-1:0]       quo_q;
	logic [btm_pkg::WIDTH_W+1:0]     trial;
	logic                            fits;

	always_comb begin
		trial = {1'b0, rem_q, dvd_q[btm_pkg::DVD_W-1]} - {2'b00, dvs_q};
		fits  = !trial[btm_pkg::WIDTH_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == btm_pkg::DIV_CNT_W'(btm_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvs_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? trial[btm_pkg::WIDTH_W-1:0]
				: {rem_q[btm_pkg::WIDTH_W-2:0], dvd_q[btm_pkg::DVD_W-1]};
			dvd_q <= {dvd_q[btm_pkg::DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[btm_pkg::DVD_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* sv/btm_blend.sv */
// ----------------------------------------------------------------------------
// btm_blend
// Smoothing update old + w*(sample-old) with round half up, as a shift-add
// multiply over one weight bit per cycle.
// ----------------------------------------------------------------------------
module btm_blend (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [btm_pkg::WEIGHT_W-1:0]  weight,
	input  logic [btm_pkg::RATE_W-1:0]    old_rate,
	input  logic [btm_pkg::RATE_W-1:0]    sample,
	output logic                          done,
	output logic [btm_pkg::RATE_W-1:0]    new_rate
);

	localparam int DIFF_W = btm_pkg::RATE_W + 1 + btm_pkg::WEIGHT_W;
	localparam int ACC_W  = DIFF_W + 1;

	logic                            busy_q;
	logic                            done_q;
	logic [btm_pkg::MUL_CNT_W-1:0]   step_q;
	logic [ACC_W-1:0]                acc_q;
	logic [DIFF_W-1:0]               diff_q;
	logic [btm_pkg::WEIGHT_W-1:0]    wt_q;
	logic [btm_pkg::RATE_W:0]        diff0;

	assign diff0 = {1'b0, sample} - {1'b0, old_rate};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == btm_pkg::MUL_CNT_W'(btm_pkg::MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= {{(ACC_W - btm_pkg::RATE_W - btm_pkg::FRAC_W){1'b0}},
				old_rate, btm_pkg::ROUND_HALF};
			diff_q <= {{(DIFF_W - btm_pkg::RATE_W - 1){diff0[btm_pkg::RATE_W]}}, diff0};
			wt_q   <= weight;
		end else if (busy_q) begin
			if (wt_q[0])
				acc_q <= acc_q + {diff_q[DIFF_W-1], diff_q};
			diff_q <= {diff_q[DIFF_W-2:0], 1'b0};
			wt_q   <= {1'b0, wt_q[btm_pkg::WEIGHT_W-1:1]};
		end
	end

	assign done     = done_q;
	assign new_rate = acc_q[btm_pkg::FRAC_W+btm_pkg::RATE_W-1:btm_pkg::FRAC_W];

endmodule

/* sv/binned_throughput_ewma.sv */
// ----------------------------------------------------------------------------
// binned_throughput_ewma
// Throughput meter over fixed time bins with exponentially weighted smoothing.
//
// Packet events enter on the item channel (item_valid / item_stall), results
// leave on the result channel (result_valid / result_stall), registers are
// written on the cfg channel (cfg_valid / cfg_ready), taken only while idle.
// A receive event inside the current bin, or a non-receive event, is taken
// in the idle state and leaves the block idle. A closing event first runs a
// 32-step division for the number of catch-up bins when there are any; each
// closed bin then runs a 32-step division for the raw rate, skipped for a bin
// with no bits or a saturated rate, plus a 16-step multiply for the smoothing.
// The serial divider is shared by both divisions. One event is worked on at a
// time; item_stall is high until its bins are all applied.
// A result waits in the output register while result_stall is high and the
// controller holds until the register is free. Reset restores the register
// defaults and clears bin start, bit count and smoothed rate.
// ----------------------------------------------------------------------------
module binned_throughput_ewma (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic                             is_receive,
	input  logic [btm_pkg::TS_W-1:0]         timestamp_us,
	input  logic [btm_pkg::BYTES_W-1:0]      packet_bytes,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [btm_pkg::TS_W-1:0]         bin_end_us,
	output logic [btm_pkg::RATE_W-1:0]       rate_mbps_q16,
	output logic [btm_pkg::BYTES_W-1:0]      packet_bytes_out,
	output logic                             is_first_close,
	output logic                             last,
	output logic                             truncated,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [btm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [btm_pkg::CFG_DAT_W-1:0]    cfg_data
);

	btm_pkg::state_t state_q, state_d;

	logic [btm_pkg::WIDTH_W-1:0]   bin_width_q;
	logic [btm_pkg::TS_W-1:0]      cutoff_q;
	logic [btm_pkg::WEIGHT_W-1:0]  weight_q;
	logic [btm_pkg::TS_W-1:0]      bin_start_q;
	logic [btm_pkg::BITS_W-1:0]    bit_count_q;
	logic [btm_pkg::RATE_W-1:0]    rate_q;
	logic [btm_pkg::COUNT_W-1:0]   n_q;
	logic                          result_valid_q;

	logic [btm_pkg::TS_W-1:0]      ts_q;
	logic [btm_pkg::BYTES_W-1:0]   bytes_q;
	logic                          emit_q;
	logic [btm_pkg::TS_W:0]        start1_q;
	logic [btm_pkg::TS_W-1:0]      fin_start_q;
	logic [btm_pkg::TS_W-1:0]      cur_start_q;
	logic [btm_pkg::TS_W-1:0]      m_q;
	logic                          first_q;
	logic [btm_pkg::RATE_W-1:0]    sample_q;

	logic [btm_pkg::TS_W-1:0]      res_end_q;
	logic [btm_pkg::RATE_W-1:0]    res_rate_q;
	logic [btm_pkg::BYTES_W-1:0]   res_bytes_q;
	logic                          res_first_q;
	logic                          res_last_q;
	logic                          res_trunc_q;

	logic [btm_pkg::WIDTH_W-1:0]   w_eff;
	logic [btm_pkg::TS_W:0]        bin_limit;
	logic                          in_bin;
	logic [btm_pkg::BITS_W:0]      bit_sum;
	logic                          item_acc;
	logic [btm_pkg::TS_W+2:0]      dd;
	logic                          many;
	logic                          samp_sat;
	logic                          samp_zero;
	logic                          show;
	logic                          settle;
	logic                          slot_free;
	logic                          load;
	logic                          go_on;
	logic                          last_hit;

	logic                          div_start;
	logic [btm_pkg::WIDTH_W-1:0]   div_rem_init;
	logic [btm_pkg::DVD_W-1:0]     div_dividend;
	logic                          div_done;
	logic [btm_pkg::DVD_W-1:0]     div_quo;
	logic [btm_pkg::WIDTH_W-1:0]   div_rem;
	logic                          blend_start;
	logic                          blend_done;
	logic [btm_pkg::RATE_W-1:0]    blend_res;

	btm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.divisor   (w_eff),
		.rem_init  (div_rem_init),
		.dividend  (div_dividend),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	btm_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (blend_start),
		.weight   (weight_q),
		.old_rate (rate_q),
		.sample   (sample_q),
		.done     (blend_done),
		.new_rate (blend_res)
	);

	always_comb begin
		w_eff     = (bin_width_q == '0) ? btm_pkg::WIDTH_W'(1) : bin_width_q;
		bin_limit = {1'b0, bin_start_q} + {9'b0, w_eff};
		in_bin    = {1'b0, timestamp_us} <= bin_limit;
		bit_sum   = {1'b0, bit_count_q} + {14'b0, packet_bytes, 3'b000};
		item_acc  = item_valid && !item_stall;
		dd        = {3'b000, ts_q} - {2'b00, start1_q} - {11'b0, w_eff} - 35'd1;
		many      = !dd[btm_pkg::TS_W+2] && (dd[btm_pkg::TS_W+1:0] >= {10'b0, w_eff});
		samp_sat  = {8'b0, bit_count_q[btm_pkg::BITS_W-1:16]} >= w_eff;
		samp_zero = bit_count_q == '0;
		show      = emit_q && (n_q < btm_pkg::COUNT_W'(btm_pkg::MAX_RESULTS));
		settle    = !first_q && samp_zero && (blend_res == rate_q);
		slot_free = !result_valid_q || !result_stall;
		last_hit  = n_q == btm_pkg::COUNT_W'(btm_pkg::MAX_RESULTS - 1);
		load      = (state_q == btm_pkg::ST_EMIT) && slot_free;
		go_on     = ((state_q == btm_pkg::ST_BWAIT) && blend_done && !show
				&& (m_q != '0) && !settle)
			|| (load && (m_q != '0));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			btm_pkg::ST_IDLE:
				if (item_acc && is_receive && !in_bin)
					state_d = btm_pkg::ST_PREP;
			btm_pkg::ST_PREP:
				state_d = many ? btm_pkg::ST_MDIV : btm_pkg::ST_SAMPLE;
			btm_pkg::ST_MDIV:
				if (div_done)
					state_d = btm_pkg::ST_SAMPLE;
			btm_pkg::ST_SAMPLE:
				state_d = (samp_sat || samp_zero) ? btm_pkg::ST_BLEND : btm_pkg::ST_RDIV;
			btm_pkg::ST_RDIV:
				if (div_done)
					state_d = btm_pkg::ST_BLEND;
			btm_pkg::ST_BLEND:
				state_d = btm_pkg::ST_BWAIT;
			btm_pkg::ST_BWAIT:
				if (blend_done) begin
					if (show)
						state_d = btm_pkg::ST_EMIT;
					else if ((m_q == '0) || settle)
						state_d = btm_pkg::ST_FINISH;
					else
						state_d = btm_pkg::ST_SAMPLE;
				end
			btm_pkg::ST_EMIT:
				if (slot_free)
					state_d = (m_q == '0) ? btm_pkg::ST_FINISH : btm_pkg::ST_SAMPLE;
			btm_pkg::ST_FINISH:
				state_d = btm_pkg::ST_IDLE;
			default:
				state_d = btm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall   = state_q != btm_pkg::ST_IDLE;
		cfg_ready    = state_q == btm_pkg::ST_IDLE;
		div_start    = 1'b0;
		div_rem_init = {8'b0, bit_count_q[btm_pkg::BITS_W-1:16]};
		div_dividend = {bit_count_q[15:0], 16'h0000};
		blend_start  = 1'b0;
		case (state_q)
			btm_pkg::ST_PREP: begin
				div_start    = many;
				div_rem_init = '0;
				div_dividend = dd[btm_pkg::DVD_W-1:0];
			end
			btm_pkg::ST_SAMPLE:
				div_start = !samp_sat && !samp_zero;
			btm_pkg::ST_BLEND:
				blend_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= btm_pkg::ST_IDLE;
			bin_width_q    <= btm_pkg::WIDTH_RESET;
			cutoff_q       <= btm_pkg::CUTOFF_RESET;
			weight_q       <= btm_pkg::WEIGHT_RESET;
			bin_start_q    <= '0;
			bit_count_q    <= '0;
			rate_q         <= '0;
			n_q            <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					btm_pkg::REG_BIN_WIDTH:    bin_width_q <= cfg_data[btm_pkg::WIDTH_W-1:0];
					btm_pkg::REG_OUTPUT_AFTER: cutoff_q    <= cfg_data[btm_pkg::TS_W-1:0];
					btm_pkg::REG_SMOOTHING:    weight_q    <= cfg_data[btm_pkg::WEIGHT_W-1:0];
					default: ;
				endcase
			end
			if ((state_q == btm_pkg::ST_IDLE) && item_acc && is_receive) begin
				if (in_bin)
					bit_count_q <= bit_sum[btm_pkg::BITS_W] ? '1 : bit_sum[btm_pkg::BITS_W-1:0];
				else
					n_q <= '0;
			end
			if ((state_q == btm_pkg::ST_BWAIT) && blend_done) begin
				rate_q      <= blend_res;
				bit_count_q <= first_q ? {13'b0, bytes_q, 3'b000} : '0;
			end
			if (load)
				n_q <= n_q + 1'b1;
			if (state_q == btm_pkg::ST_FINISH)
				bin_start_q <= fin_start_q;
			if (load)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == btm_pkg::ST_IDLE) && item_acc && is_receive && !in_bin) begin
			ts_q        <= timestamp_us;
			bytes_q     <= packet_bytes;
			emit_q      <= timestamp_us > cutoff_q;
			start1_q    <= bin_limit;
			cur_start_q <= bin_limit[btm_pkg::TS_W-1:0];
			first_q     <= 1'b1;
		end
		if ((state_q == btm_pkg::ST_PREP) && !many) begin
			m_q         <= '0;
			fin_start_q <= start1_q[btm_pkg::TS_W-1:0];
		end
		if ((state_q == btm_pkg::ST_MDIV) && div_done) begin
			m_q         <= div_quo;
			fin_start_q <= ts_q - {8'b0, w_eff} - 32'd1 - {8'b0, div_rem};
		end
		if (state_q == btm_pkg::ST_SAMPLE)
			sample_q <= samp_sat ? '1 : '0;
		if ((state_q == btm_pkg::ST_RDIV) && div_done)
			sample_q <= div_quo;
		if (go_on) begin
			m_q         <= m_q - 1'b1;
			cur_start_q <= cur_start_q + {8'b0, w_eff};
			first_q     <= 1'b0;
		end
		if (load) begin
			res_end_q   <= cur_start_q;
			res_rate_q  <= rate_q;
			res_bytes_q <= bytes_q;
			res_first_q <= first_q;
			res_last_q  <= (m_q == '0) || last_hit;
			res_trunc_q <= last_hit && (m_q != '0);
		end
	end

	assign result_valid     = result_valid_q;
	assign bin_end_us       = res_end_q;
	assign rate_mbps_q16    = res_rate_q;
	assign packet_bytes_out = res_bytes_q;
	assign is_first_close   = res_first_q;
	assign last             = res_last_q;
	assign truncated        = res_trunc_q;

endmodule

/* sv/btm_checker.sv */
// ----------------------------------------------------------------------------
// btm_checker
// Port-level checks of the binned throughput meter, bound to the top level.
// ----------------------------------------------------------------------------
module btm_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	input  logic                             item_stall,
	input  logic                             is_receive,
	input  logic                             result_valid,
	input  logic                             result_stall,
	input  logic [btm_pkg::TS_W-1:0]         bin_end_us,
	input  logic [btm_pkg::RATE_W-1:0]       rate_mbps_q16,
	input  logic [btm_pkg::BYTES_W-1:0]      packet_bytes_out,
	input  logic                             is_first_close,
	input  logic                             last,
	input  logic                             truncated,
	input  logic                             cfg_ready
);

	a_cfg_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == !item_stall)
		else $error("cfg_ready disagrees with item channel idleness");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared without a transaction in progress");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(bin_end_us)
			&& $stable(rate_mbps_q16) && $stable(packet_bytes_out)
			&& $stable(is_first_close) && $stable(last) && $stable(truncated))
		else $error("stalled result changed");

	a_trunc_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && truncated |-> last)
		else $error("truncated flagged on a result that is not the last");

	a_ignore_other: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && !is_receive |=> !item_stall)
		else $error("non-receive transaction left the block busy");

endmodule

bind binned_throughput_ewma btm_checker u_btm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.item_valid       (item_valid),
	.item_stall       (item_stall),
	.is_receive       (is_receive),
	.result_valid     (result_valid),
	.result_stall     (result_stall),
	.bin_end_us       (bin_end_us),
	.rate_mbps_q16    (rate_mbps_q16),
	.packet_bytes_out (packet_bytes_out),
	.is_first_close   (is_first_close),
	.last             (last),
	.truncated        (truncated),
	.cfg_ready        (cfg_ready)
);

/* test/btm_meter_check.sv */
// ----------------------------------------------------------------------------
// btm_meter_check
// Watches the item, result and register channels of the throughput meter,
// keeps its own copy of the bin state and the register settings, works out
// the closed bins that every accepted packet event causes, and compares each
// result transaction field by field with the oldest predicted bin.
// ----------------------------------------------------------------------------
module btm_meter_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  logic                          item_stall,
	input  logic                          is_receive,
	input  logic [btm_pkg::TS_W-1:0]      timestamp_us,
	input  logic [btm_pkg::BYTES_W-1:0]   packet_bytes,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic [btm_pkg::TS_W-1:0]      bin_end_us,
	input  logic [btm_pkg::RATE_W-1:0]    rate_mbps_q16,
	input  logic [btm_pkg::BYTES_W-1:0]   packet_bytes_out,
	input  logic                          is_first_close,
	input  logic                          last,
	input  logic                          truncated,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [btm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [btm_pkg::CFG_DAT_W-1:0] cfg_data,
	output int                            fail_count,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import btm_pkg::*;

	typedef struct packed {
		logic [TS_W-1:0]    bin_end;
		logic [RATE_W-1:0]  rate;
		logic [BYTES_W-1:0] nbytes;
		logic               first_close;
		logic               final_flag;
		logic               trunc;
	} bin_result_t;

	bin_result_t closed_bins_q[$];
	bin_result_t want;

	logic [WIDTH_W-1:0]  width_r;
	logic [TS_W-1:0]     cutoff_r;
	logic [WEIGHT_W-1:0] weight_r;
	logic [TS_W-1:0]     start_r;
	logic [BITS_W-1:0]   bits_r;
	logic [RATE_W-1:0]   rate_r;

	function automatic logic [RATE_W-1:0] bin_rate(logic [BITS_W-1:0] nbits, longint w);
		logic [63:0] q;
		q = ({32'h0, nbits} << FRAC_W) / w;
		return (q[63:RATE_W] != '0) ? '1 : q[RATE_W-1:0];
	endfunction

	function automatic logic [RATE_W-1:0] smooth_rate(logic [RATE_W-1:0] prior,
			logic [RATE_W-1:0] smp);
		logic [63:0] acc;
		acc = {48'h0, weight_r} * {32'h0, smp}
			+ (64'h1_0000 - {48'h0, weight_r}) * {32'h0, prior}
			+ {48'h0, ROUND_HALF};
		return acc[47:16];
	endfunction

	task automatic predict_event(logic rx, logic [TS_W-1:0] ts, logic [BYTES_W-1:0] nb);
		longint w, stamp, base, start, diff, m;
		logic [BITS_W-1:0] pbits, carried;
		logic [BITS_W:0] sum;
		logic [RATE_W-1:0] prev;
		bit emit, trunc, have_tail;
		int n;
		bin_result_t tail;
		if (!rx)
			return;
		w = width_r;
		if (w == 0)
			w = 1;
		stamp = ts;
		base = start_r;
		pbits = {13'd0, nb, 3'd0};
		diff = stamp - base;
		if (diff <= w) begin
			sum = {1'b0, bits_r} + {1'b0, pbits};
			bits_r = sum[BITS_W] ? '1 : sum[BITS_W-1:0];
			return;
		end
		emit = ts > cutoff_r;
		trunc = 1'b0;
		have_tail = 1'b0;
		n = 0;
		rate_r = smooth_rate(rate_r, bin_rate(bits_r, w));
		start = base + w;
		bits_r = pbits;
		if (emit) begin
			tail = '{start[TS_W-1:0], rate_r, nb, 1'b1, 1'b0, 1'b0};
			have_tail = 1'b1;
			n = 1;
		end
		diff = stamp - start;
		m = (diff > 2 * w) ? (diff - w - 1) / w : 0;
		while (m > 0) begin
			carried = bits_r;
			prev = rate_r;
			rate_r = smooth_rate(rate_r, bin_rate(carried, w));
			bits_r = '0;
			start += w;
			m--;
			if (emit && n < MAX_RESULTS) begin
				closed_bins_q.push_back(tail);
				tail = '{start[TS_W-1:0], rate_r, nb, 1'b0, 1'b0, 1'b0};
				n++;
			end else begin
				if (emit)
					trunc = 1'b1;
				// skip the rest of an idle run once the rate has settled
				if (carried == '0 && rate_r == prev) begin
					start += m * w;
					m = 0;
				end
			end
		end
		start_r = start[TS_W-1:0];
		if (have_tail) begin
			tail.final_flag = 1'b1;
			tail.trunc = trunc;
			closed_bins_q.push_back(tail);
		end
	endtask

	function automatic void check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
				act_val);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_r = WIDTH_RESET;
			cutoff_r = CUTOFF_RESET;
			weight_r = WEIGHT_RESET;
			start_r = '0;
			bits_r = '0;
			rate_r = '0;
			closed_bins_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BIN_WIDTH:    width_r = cfg_data[WIDTH_W-1:0];
					REG_OUTPUT_AFTER: cutoff_r = cfg_data[TS_W-1:0];
					REG_SMOOTHING:    weight_r = cfg_data[WEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall)
				predict_event(is_receive, timestamp_us, packet_bytes);
			if (result_valid && !result_stall) begin
				if (closed_bins_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual bin_end %0h rate %0h",
						$time, bin_end_us, rate_mbps_q16);
					fail_count++;
				end else begin
					want = closed_bins_q.pop_front();
					check_field("bin_end_us", 64'(want.bin_end), 64'(bin_end_us));
					check_field("rate_mbps_q16", 64'(want.rate), 64'(rate_mbps_q16));
					check_field("packet_bytes_out", 64'(want.nbytes),
						64'(packet_bytes_out));
					check_field("is_first_close", 64'(want.first_close),
						64'(is_first_close));
					check_field("last", 64'(want.final_flag), 64'(last));
					check_field("truncated", 64'(want.trunc), 64'(truncated));
				end
			end
			pending = closed_bins_q.size();
		end
	end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the binned throughput meter. A directed run covers
// boundary timestamps, ignored events, zero and maximum bin widths, truncated
// catch-up runs and the output cutoff; random phases then mix in-bin packets,
// closings, long gaps and out-of-order stamps under changing register settings
// and sender/receiver idling.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import btm_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam longint MAX_STAMP = 64'h0000_0000_FFFF_FFFF;
	localparam int SETTLE_CYCLES = 6000;
	localparam int BURST_ITEMS = 8;
	localparam int HALF_ITEMS = 54;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	logic                 is_receive;
	logic [TS_W-1:0]      timestamp_us;
	logic [BYTES_W-1:0]   packet_bytes;
	logic                 result_valid;
	logic                 result_stall;
	logic [TS_W-1:0]      bin_end_us;
	logic [RATE_W-1:0]    rate_mbps_q16;
	logic [BYTES_W-1:0]   packet_bytes_out;
	logic                 is_first_close;
	logic                 last;
	logic                 truncated;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int send_idle_pct;
	int stall_pct;
	longint now_us;

	binned_throughput_ewma DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.is_receive       (is_receive),
		.timestamp_us     (timestamp_us),
		.packet_bytes     (packet_bytes),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.bin_end_us       (bin_end_us),
		.rate_mbps_q16    (rate_mbps_q16),
		.packet_bytes_out (packet_bytes_out),
		.is_first_close   (is_first_close),
		.last             (last),
		.truncated        (truncated),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	btm_meter_check meter_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.is_receive       (is_receive),
		.timestamp_us     (timestamp_us),
		.packet_bytes     (packet_bytes),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.bin_end_us       (bin_end_us),
		.rate_mbps_q16    (rate_mbps_q16),
		.packet_bytes_out (packet_bytes_out),
		.is_first_close   (is_first_close),
		.last             (last),
		.truncated        (truncated),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.fail_count       (fail_count),
		.pending          (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			result_stall <= ($urandom_range(99, 0) < stall_pct);
		end
	end

	task automatic send_event(logic rx, logic [TS_W-1:0] ts, logic [BYTES_W-1:0] nb);
		@(negedge clk);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			item_valid <= 1'b0;
			is_receive <= 1'($urandom_range(1, 0));
			timestamp_us <= $urandom;
			packet_bytes <= BYTES_W'($urandom_range(65535, 0));
			@(negedge clk);
		end
		item_valid <= 1'b1;
		is_receive <= rx;
		timestamp_us <= ts;
		packet_bytes <= nb;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	// drop valid, drain the predicted bins, then let silent bins finish
	task automatic settle_meter();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int w, sel, pick, sent;
		longint cut, delta, back;
		logic [CFG_DAT_W-1:0] wd;
		logic [TS_W-1:0] ts;
		arst_n = 1'b0;
		item_valid = 1'b0;
		is_receive = 1'b0;
		timestamp_us = '0;
		packet_bytes = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_BIN_WIDTH;
		cfg_data = '0;
		send_idle_pct = 36;
		stall_pct = 55;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_event(1'b0, 32'hFFFF_FFFF, 16'hFFFF);
		send_event(1'b1, 32'd0, 16'd0);
		send_event(1'b1, 32'd100000, 16'hFFFF);
		send_event(1'b1, 32'd100001, 16'd1);
		send_event(1'b1, 32'd500002, 16'd1234);
		send_event(1'b1, 32'd0, 16'd100);

		settle_meter();
		write_reg(REG_BIN_WIDTH, 32'hFFFF_FFFF);
		write_reg(REG_SMOOTHING, 32'hFFFF_FFFF);
		repeat (BURST_ITEMS) send_event(1'b1, 32'd0, 16'hFFFF);
		send_event(1'b1, 32'd17300000, 16'hFFFF);

		settle_meter();
		write_reg(REG_BIN_WIDTH, 32'hFF00_0000);
		send_event(1'b1, 32'd17300000, 16'hFFFF);

		settle_meter();
		write_reg(REG_SMOOTHING, 32'h0);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		send_event(1'b1, 32'd17300002, 16'd9);
		now_us = 17300002;

		for (int phase = 0; phase < 3; phase++) begin
			for (int half = 0; half < 2; half++) begin
				sel = $urandom_range(2, 0);
				if (sel == 0)
					w = $urandom_range(64, 1);
				else if (sel == 1)
					w = $urandom_range(5000, 1);
				else
					w = $urandom_range(1048575, 1000);
				wd = $urandom;
				wd[WIDTH_W-1:0] = w[WIDTH_W-1:0];
				cut = now_us + longint'(w) * $urandom_range(30, 0);
				if (cut > MAX_STAMP)
					cut = MAX_STAMP;
				settle_meter();
				if (phase == 0) begin
					send_idle_pct = 36;
					stall_pct = 55;
				end else if (phase == 1) begin
					send_idle_pct = 55;
					stall_pct = 36;
				end else begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				write_reg(REG_BIN_WIDTH, wd);
				write_reg(REG_OUTPUT_AFTER, cut[TS_W-1:0]);
				write_reg(REG_SMOOTHING, $urandom);
				sent = 0;
				while (sent < HALF_ITEMS) begin
					pick = $urandom_range(99, 0);
					if (pick < 10) begin
						send_event(1'b0, $urandom, BYTES_W'($urandom_range(65535, 0)));
					end else begin
						if (pick < 96) begin
							if (pick < 60)
								delta = $urandom_range(w / 4, 0);
							else if (pick < 85)
								delta = $urandom_range(3 * w, w);
							else if (pick < 92)
								delta = $urandom_range(20 * w, 3 * w);
							else
								delta = $urandom_range(90 * w, 64 * w);
							now_us = now_us + delta;
							if (now_us > MAX_STAMP)
								now_us = MAX_STAMP;
							ts = now_us[TS_W-1:0];
						end else begin
							back = $urandom_range(3 * w, 0);
							ts = (now_us > back) ? TS_W'(now_us - back) : '0;
						end
						send_event(1'b1, ts, BYTES_W'($urandom_range(65535, 0)));
						sent++;
					end
				end
			end
		end

		settle_meter();
		write_reg(REG_OUTPUT_AFTER, 32'hFFFF_FFFF);
		write_reg(REG_SMOOTHING, 32'd32768);
		write_reg(REG_BIN_WIDTH, 32'h00FF_FFFF);
		send_event(1'b1, 32'hFFFF_FFFF, 16'hFFFF);
		send_event(1'b1, 32'hFFFF_FFFF, 16'd3);

		settle_meter();
		write_reg(REG_OUTPUT_AFTER, 32'hFFFF_FFFE);
		send_event(1'b1, 32'hFFFF_FFFF, 16'd0);
		send_event(1'b0, 32'h1234_5678, 16'h5A5A);

		settle_meter();
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
